@@ hw/rtl/prs80_pkg.sv @@
// Shared constants and round functions for the PRESENT-80 cipher pipeline.
// S-box tables, bit permutations and the forward/inverse key update.
// No dependencies.
`default_nettype none

package prs80_pkg;

    localparam int unsigned BLOCK_W     = 64;
    localparam int unsigned KEY_W       = 80;
    localparam int unsigned KEY_UPPER_W = 16;
    localparam int unsigned RC_W        = 5;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned ROUND_COUNT = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] SBOX_DEC [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = SBOX_FWD[v[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] sbox_dec_layer(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = SBOX_DEC[v[4*n +: 4]];
        end
        return r;
    endfunction

    // Bit i moves to 16*i mod 63; the top bit stays in place.
    function automatic logic [BLOCK_W-1:0] p_layer(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            r[(16 * i) % (BLOCK_W - 1)] = v[i];
        end
        r[BLOCK_W-1] = v[BLOCK_W-1];
        return r;
    endfunction

    // Inverse permutation: bit i moves to 4*i mod 63.
    function automatic logic [BLOCK_W-1:0] p_inv_layer(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            r[(4 * i) % (BLOCK_W - 1)] = v[i];
        end
        r[BLOCK_W-1] = v[BLOCK_W-1];
        return r;
    endfunction

    // Rotate left by 61, S-box on top nibble, round counter into bits 19..15.
    function automatic logic [KEY_W-1:0] key_fwd(input logic [KEY_W-1:0] k,
                                                 input logic [RC_W-1:0]  rc);
        logic [KEY_W-1:0] t;
        t = {k[18:0], k[79:19]};
        t[79:76] = SBOX_FWD[t[79:76]];
        t[19:15] = t[19:15] ^ rc;
        return t;
    endfunction

    // Undo key_fwd for the same round counter.
    function automatic logic [KEY_W-1:0] key_inv(input logic [KEY_W-1:0] k,
                                                 input logic [RC_W-1:0]  rc);
        logic [KEY_W-1:0] t;
        t = k;
        t[19:15] = t[19:15] ^ rc;
        t[79:76] = SBOX_DEC[t[79:76]];
        return {t[60:0], t[79:61]};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/prs80_in_if.sv @@
// Input channel of the PRESENT-80 pipeline: valid/ready plus operation and block.
// Depends on prs80_pkg for the block width.
`default_nettype none

interface prs80_in_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [prs80_pkg::BLOCK_W-1:0]   block_in;

    modport source (output valid, output operation, output block_in, input ready);
    modport sink   (input valid, input operation, input block_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/prs80_out_if.sv @@
// Output channel of the PRESENT-80 pipeline: valid/ready plus result block.
// Depends on prs80_pkg for the block width.
`default_nettype none

interface prs80_out_if;
    logic                            valid;
    logic                            ready;
    logic [prs80_pkg::BLOCK_W-1:0]   block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/present80_block_cipher.sv @@
// PRESENT-80 encrypt/decrypt pipeline, one round per register stage.
// Depends on prs80_pkg, prs80_in_if and prs80_out_if.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------
//  i_blk    | in  | valid/ready       | operation, block_in[63:0]
//  o_blk    | out | valid/ready       | block_out[63:0]
//  i_cfg_*  | in  | write enable only | i_cfg_idx, i_cfg_data[63:0]
//
// One block enters per cycle while i_blk.ready is high; results leave via the output register.
// The first ROUND_COUNT stages advance the key schedule and run encrypt rounds;
// the next ROUND_COUNT stages walk the schedule back and run decrypt rounds.
// Reset clears valid bits and the key registers; no clearing pass is needed.
// An output register with a one-entry skid absorbs downstream stalls; the
// pipeline freezes only while the skid is full, and i_blk.ready is registered.
`default_nettype none

module present80_block_cipher #(
    parameter int unsigned ROUND_COUNT = prs80_pkg::ROUND_COUNT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [prs80_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [prs80_pkg::BLOCK_W-1:0]     i_cfg_data,
    prs80_in_if.sink                               i_blk,
    prs80_out_if.source                            o_blk
);
    import prs80_pkg::*;

    localparam int unsigned STAGES = 2 * ROUND_COUNT;

    logic [KEY_UPPER_W-1:0] r_key_upper;
    logic [BLOCK_W-1:0]     r_key_lower;

    logic                   r_valid [STAGES];
    logic                   r_op    [STAGES];
    logic [BLOCK_W-1:0]     r_data  [STAGES];
    logic [KEY_W-1:0]       r_key   [STAGES];

    logic                   n_valid [STAGES];
    logic                   n_op    [STAGES];
    logic [BLOCK_W-1:0]     n_data  [STAGES];
    logic [KEY_W-1:0]       n_key   [STAGES];

    logic                   w_pv    [STAGES];
    logic                   w_pop   [STAGES];
    logic [BLOCK_W-1:0]     w_pdata [STAGES];
    logic [KEY_W-1:0]       w_pkey  [STAGES];

    logic                   r_out_v;
    logic [BLOCK_W-1:0]     r_out_data;
    logic                   r_skid_v;
    logic [BLOCK_W-1:0]     r_skid_data;

    logic                   w_en;
    logic                   w_take;
    logic                   w_last_v;

    assign w_en     = !r_skid_v;
    assign w_take   = r_out_v && o_blk.ready;
    assign w_last_v = r_valid[STAGES-1];

    assign i_blk.ready     = w_en;
    assign o_blk.valid     = r_out_v;
    assign o_blk.block_out = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_UPPER: r_key_upper <= i_cfg_data[KEY_UPPER_W-1:0];
                REG_KEY_LOWER: r_key_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Source of each stage: the input port for the first, else the stage before.
    always_comb begin
        w_pv[0]    = i_blk.valid;
        w_pop[0]   = i_blk.operation;
        w_pdata[0] = i_blk.block_in;
        w_pkey[0]  = {r_key_upper, r_key_lower};
        for (int k = 1; k < STAGES; k++) begin
            w_pv[k]    = r_valid[k-1];
            w_pop[k]   = r_op[k-1];
            w_pdata[k] = r_data[k-1];
            w_pkey[k]  = r_key[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            n_valid[k] = w_pv[k];
            n_op[k]    = w_pop[k];
            if (k < ROUND_COUNT) begin
                // Forward half: key advances; encrypt round k uses the key before update.
                n_key[k] = key_fwd(w_pkey[k], RC_W'(k + 1));
                if (!w_pop[k]) begin
                    n_data[k] = p_layer(sbox_layer(w_pdata[k] ^ w_pkey[k][KEY_W-1:16]));
                end else begin
                    n_data[k] = w_pdata[k];
                end
                // Last forward stage: final whitening for encrypt, first for decrypt.
                if (k == ROUND_COUNT - 1) begin
                    n_data[k] = n_data[k] ^ n_key[k][KEY_W-1:16];
                end
            end else begin
                // Reverse half: walk the schedule back; decrypt uses the restored key.
                n_key[k] = key_inv(w_pkey[k], RC_W'(STAGES - k));
                if (w_pop[k]) begin
                    n_data[k] = sbox_dec_layer(p_inv_layer(w_pdata[k]))
                                ^ n_key[k][KEY_W-1:16];
                end else begin
                    n_data[k] = w_pdata[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            for (int k = 0; k < STAGES; k++) begin
                r_valid[k] <= n_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < STAGES; k++) begin
                r_op[k]   <= n_op[k];
                r_data[k] <= n_data[k];
                r_key[k]  <= n_key[k];
            end
        end
    end

    // Output register and skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
                r_skid_v   <= 1'b0;
            end
        end else if (w_last_v) begin
            if (!r_out_v || w_take) begin
                r_out_v    <= 1'b1;
                r_out_data <= r_data[STAGES-1];
            end else begin
                r_skid_v    <= 1'b1;
                r_skid_data <= r_data[STAGES-1];
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds a transaction while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_v && w_last_v && r_out_v && !o_blk.ready) |=> r_skid_v)
        else $error("pipeline output lost while output was stalled");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && o_blk.ready) |=> (!r_skid_v && r_out_v))
        else $error("skid entry did not move to the output register");
`endif

endmodule

`default_nettype wire
